@@ hdl/hpcs_pkg.sv @@
// types and constants shared by the root hub port attach sequencer
`default_nettype none

package hpcs_pkg;

  localparam int unsigned PortCount = 8;
  localparam int unsigned PortW     = 3;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned TimerW    = 10;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned EventW    = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [TimerW-1:0] DebounceReset  = TimerW'(400);
  localparam logic [TimerW-1:0] ResetReset     = TimerW'(50);
  localparam logic [TimerW-1:0] LongResetReset = TimerW'(200);
  localparam logic [TimerW-1:0] RecoveryReset  = TimerW'(5);

  typedef enum logic [CmdW-1:0] {
    CMD_POLL  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CFG   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_RESET    = 3'd2,
    PH_ENWAIT   = 3'd3,
    PH_AWAIT    = 3'd4,
    PH_PAUSE    = 3'd5,
    PH_LONGRST  = 3'd6
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE       = 3'd0,
    EV_ATTACH     = 3'd1,
    EV_BOUNCE     = 3'd2,
    EV_GONE       = 3'd3,
    EV_CONFIGURED = 3'd4,
    EV_RETRY      = 3'd5,
    EV_DETACHED   = 3'd6
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_RESET     = 2'd1,
    CFG_LONGRST   = 2'd2,
    CFG_RECOVERY  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [PortW-1:0] port;
    logic             connected;
    logic             change;
    logic             enabled;
    logic             low_speed;
    logic             config_ok;
  } in_item_t;

  typedef struct packed {
    logic suspend;
    logic reset;
    logic enable;
  } drive_t;

endpackage

`default_nettype wire

@@ hdl/hub_port_connect_sequencer.sv @@
// root hub port attach sequencer: debounce, reset, enable and retry handling
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  in       | in_valid_i, in_stall_o, item fields  | to block
//  out      | out_valid_o, out_stall_i, results    | from block
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i    | to block
//
// one item per cycle sustained while out_stall_i is low; an item waits in the input
// register, is decided there by the phase and timer logic and is loaded into the result
// register whenever that register is empty or not stalled, which raises out_valid_o;
// the result transfers out of the result register when out_stall_i is low
// reset puts the sequencer idle with all drive bits low and timers at their defaults
// in_stall_o rises only when the input register holds an item and the result
// register is full and stalled
`default_nettype none

module hub_port_connect_sequencer (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [hpcs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [hpcs_pkg::TimerW-1:0]       cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [hpcs_pkg::CmdW-1:0]         cmd_i,
  input  wire  [hpcs_pkg::PortW-1:0]        port_number_i,
  input  wire                               connected_i,
  input  wire                               connect_change_i,
  input  wire                               port_enabled_i,
  input  wire                               low_speed_i,
  input  wire                               config_ok_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [hpcs_pkg::PhaseW-1:0]       phase_o,
  output logic                              clear_change_o,
  output logic                              suspend_drive_o,
  output logic                              reset_drive_o,
  output logic                              enable_drive_o,
  output logic                              request_config_o,
  output logic                              device_low_speed_o,
  output logic [hpcs_pkg::PortW-1:0]        active_port_o,
  output logic [hpcs_pkg::EventW-1:0]       event_res_o
);

  import hpcs_pkg::*;

  // configuration
  logic [TimerW-1:0] debounce_q, reset_ticks_q, long_reset_q, recovery_q;

  // input register
  logic     in_valid_q;
  in_item_t in_q;

  // sequencer state
  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [PortW-1:0]  busy_port_q, busy_port_d;
  logic              retry_pend_q, retry_pend_d;
  logic [PortW-1:0]  retry_port_q, retry_port_d;
  drive_t            drive_q, drive_d;
  logic              speed_q, speed_d;

  // result register
  logic   out_valid_q;
  logic   clear_q, clear_d;
  logic   req_q, req_d;
  event_e ev_q, ev_d;
  phase_e out_phase_q;
  drive_t out_drive_q;
  logic   out_speed_q;
  logic [PortW-1:0] out_port_q;

  logic out_load, step, in_xfer;
  logic item_ok, status_mine, tick_hit;
  logic [TimerW-1:0] timer_inc, limit;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceReset;
      reset_ticks_q <= ResetReset;
      long_reset_q  <= LongResetReset;
      recovery_q    <= RecoveryReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE: debounce_q    <= cfg_data_i;
        CFG_RESET:    reset_ticks_q <= cfg_data_i;
        CFG_LONGRST:  long_reset_q  <= cfg_data_i;
        CFG_RECOVERY: recovery_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.cmd       <= cmd_e'(cmd_i);
      in_q.port      <= port_number_i;
      in_q.connected <= connected_i;
      in_q.change    <= connect_change_i;
      in_q.enabled   <= port_enabled_i;
      in_q.low_speed <= low_speed_i;
      in_q.config_ok <= config_ok_i;
    end
  end

  // phase timer limit and tick compare
  always_comb begin
    unique case (phase_q)
      PH_DEBOUNCE: limit = debounce_q;
      PH_RESET:    limit = reset_ticks_q;
      PH_PAUSE:    limit = recovery_q;
      PH_LONGRST:  limit = long_reset_q;
      default:     limit = debounce_q;
    endcase
  end

  assign timer_inc   = timer_q + TimerW'(1);
  assign tick_hit    = (timer_inc >= limit);
  assign item_ok     = ({1'b0, in_q.port} < (PortW+1)'(PortCount)) && (in_q.cmd != CMD_RSVD);
  assign status_mine = ((in_q.cmd == CMD_POLL) || (in_q.cmd == CMD_TICK)) &&
                       (in_q.port == busy_port_q);

  // next state
  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    busy_port_d  = busy_port_q;
    retry_pend_d = retry_pend_q;
    retry_port_d = retry_port_q;
    drive_d      = drive_q;
    speed_d      = speed_q;
    clear_d      = 1'b0;
    req_d        = 1'b0;
    ev_d         = EV_NONE;
    if (item_ok) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_q.cmd == CMD_POLL &&
              (in_q.change || (retry_pend_q && retry_port_q == in_q.port))) begin
            retry_pend_d = 1'b0;
            clear_d      = 1'b1;
            busy_port_d  = in_q.port;
            if (in_q.connected) begin
              phase_d = PH_DEBOUNCE;
              timer_d = '0;
              ev_d    = EV_ATTACH;
            end else begin
              drive_d.suspend = 1'b1;
              drive_d.enable  = 1'b0;
              ev_d            = EV_DETACHED;
            end
          end
        end
        PH_DEBOUNCE: begin
          if (status_mine && in_q.change) begin
            clear_d = 1'b1;
            timer_d = '0;
            ev_d    = EV_BOUNCE;
          end else if (in_q.cmd == CMD_TICK) begin
            timer_d = tick_hit ? '0 : timer_inc;
            if (tick_hit) begin
              drive_d.suspend = 1'b0;
              drive_d.reset   = 1'b1;
              phase_d         = PH_RESET;
            end
          end
        end
        PH_RESET: begin
          if (in_q.cmd == CMD_TICK) begin
            timer_d = tick_hit ? '0 : timer_inc;
            if (tick_hit) begin
              drive_d.reset  = 1'b0;
              drive_d.enable = 1'b1;
              phase_d        = PH_ENWAIT;
            end
          end
        end
        PH_ENWAIT: begin
          if (status_mine && (in_q.enabled || !in_q.connected)) begin
            if (!in_q.connected) begin
              phase_d = PH_IDLE;
              ev_d    = EV_GONE;
            end else begin
              speed_d = in_q.low_speed;
              req_d   = 1'b1;
              phase_d = PH_AWAIT;
            end
          end
        end
        PH_AWAIT: begin
          if (in_q.cmd == CMD_CFG && in_q.port == busy_port_q) begin
            if (in_q.config_ok) begin
              phase_d = PH_IDLE;
              ev_d    = EV_CONFIGURED;
            end else begin
              drive_d.enable = 1'b0;
              timer_d        = '0;
              phase_d        = PH_PAUSE;
            end
          end
        end
        PH_PAUSE: begin
          if (in_q.cmd == CMD_TICK) begin
            timer_d = tick_hit ? '0 : timer_inc;
            if (tick_hit) begin
              drive_d.reset = 1'b1;
              phase_d       = PH_LONGRST;
            end
          end
        end
        PH_LONGRST: begin
          if (in_q.cmd == CMD_TICK) begin
            timer_d = tick_hit ? '0 : timer_inc;
            if (tick_hit) begin
              drive_d.reset   = 1'b0;
              drive_d.suspend = 1'b1;
              retry_pend_d    = 1'b1;
              retry_port_d    = busy_port_q;
              phase_d         = PH_IDLE;
              ev_d            = EV_RETRY;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      timer_q      <= '0;
      busy_port_q  <= '0;
      retry_pend_q <= 1'b0;
      retry_port_q <= '0;
      drive_q      <= '0;
      speed_q      <= 1'b0;
    end else if (step) begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      busy_port_q  <= busy_port_d;
      retry_pend_q <= retry_pend_d;
      retry_port_q <= retry_port_d;
      drive_q      <= drive_d;
      speed_q      <= speed_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_phase_q <= phase_d;
      clear_q     <= clear_d;
      out_drive_q <= drive_d;
      req_q       <= req_d;
      out_speed_q <= speed_d;
      out_port_q  <= busy_port_d;
      ev_q        <= ev_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign phase_o            = out_phase_q;
  assign clear_change_o     = clear_q;
  assign suspend_drive_o    = out_drive_q.suspend;
  assign reset_drive_o      = out_drive_q.reset;
  assign enable_drive_o     = out_drive_q.enable;
  assign request_config_o   = req_q;
  assign device_low_speed_o = out_speed_q;
  assign active_port_o      = out_port_q;
  assign event_res_o        = ev_q;

endmodule

`default_nettype wire
